// ===== rtl/phnc_pkg.sv =====
// Package for the perfect and harmonic-divisor number classifier.
// Holds the widths, saturation limits and sequencer state type; no dependencies.
`default_nettype none

package phnc_pkg;

  // Width of the number under test; the low NUM_WIDTH bits of the input are used.
  localparam int NUM_WIDTH = 16;

  // Widths of the stream payload fields.
  localparam int IN_W       = 16;
  localparam int CNT_OUT_W  = 7;
  localparam int SUM_OUT_W  = 18;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_PAD_W  = OUT_DATA_W - CNT_OUT_W - SUM_OUT_W - 2;

  // Saturation limits of the result fields.
  localparam int CNT_MAX = (1 << CNT_OUT_W) - 1;
  localparam int SUM_MAX = (1 << SUM_OUT_W) - 1;

  // Internal tallies hold exact values: the count stays below 2*sqrt(n) and the
  // divisor sum stays below 8n over the whole parameter range.
  localparam int CNT_W = (NUM_WIDTH / 2 + 2 > CNT_OUT_W) ? NUM_WIDTH / 2 + 2 : CNT_OUT_W;
  localparam int SUM_W = (NUM_WIDTH + 3 > SUM_OUT_W) ? NUM_WIDTH + 3 : SUM_OUT_W;

  // Dividend width of the shared divider: wide enough for n times the count.
  localparam int PW     = NUM_WIDTH + CNT_W;
  localparam int STEP_W = $clog2(PW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_TRIAL,
    S_CHECK,
    S_HARM,
    S_FINISH
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/perfect_harmonic_number_classifier_unit.sv =====
// Top level of the perfect and harmonic-divisor number classifier.
// Uses phnc_pkg for widths, limits and the sequencer state type.
`default_nettype none

// The block takes one unsigned number n per input item and returns one result
// item with the number of divisors of n, their sum, a perfect flag (the sum is
// exactly 2n) and a harmonic-divisor flag (the sum divides n times the count).
// Zero is treated as having one divisor of value one, so it reports count 1,
// sum 1, not perfect and harmonic. All work is done by one shared restoring
// divider of PW = 26 dividend bits that retires one quotient bit per cycle.
// It first runs a trial division of n by every d from 1 up to floor(sqrt(n))+1;
// after each division the check state tests the remainder and adds the divisor
// pair d and n/d to the tallies. It then runs one more division of n times the
// count by the sum for the harmonic test. Input tready is high only while the
// sequencer is idle. The result sits in an output register, so a new item is
// accepted while the last result still waits to be taken; the sequencer only
// stalls at the end of an item if that register is still full. Counts and sums
// that do not fit their fields saturate at all ones, while both flags are
// decided on the exact values.
module perfect_harmonic_number_classifier_unit
  import phnc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_W-1:0]       s_axis_tdata,   // [15:0] value_in
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata    // [6:0] divisor_count,
                                                     // [24:7] divisor_sum,
                                                     // [25] is_perfect,
                                                     // [26] is_harmonic,
                                                     // [31:27] zero
);

  state_e state_q, state_d;

  // Number under test, trial divisor and the running tallies.
  logic [NUM_WIDTH-1:0] n_q, n_d;
  logic [NUM_WIDTH-1:0] d_q, d_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [SUM_W-1:0]     sum_q, sum_d;

  // Shared divider: partial remainder, dividend/quotient shift register,
  // divisor and the step counter.
  logic [SUM_W-1:0]  rem_q, rem_d;
  logic [PW-1:0]     quo_q, quo_d;
  logic [SUM_W-1:0]  dvs_q, dvs_d;
  logic [STEP_W-1:0] step_q, step_d;

  // Result register.
  logic                 out_valid_q, out_valid_d;
  logic [CNT_OUT_W-1:0] out_cnt_q, out_cnt_d;
  logic [SUM_OUT_W-1:0] out_sum_q, out_sum_d;
  logic                 out_perf_q, out_perf_d;
  logic                 out_harm_q, out_harm_d;

  logic                 in_fire;
  logic [NUM_WIDTH-1:0] n_in;

  // One restoring step of the divider.
  logic [SUM_W:0]   rem_shift;
  logic [SUM_W+1:0] diff;
  logic             fits;
  logic [SUM_W-1:0] rem_next;
  logic [PW-1:0]    quo_next;

  // Evaluation of one finished trial division.
  logic [PW-1:0]    d_ext;
  logic             loop_done;
  logic             pair;
  logic [SUM_W-1:0] sum_inc;
  logic [CNT_W-1:0] cnt_inc;
  logic [PW-1:0]    harm_dividend;
  logic [SUM_W-1:0] two_n;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign n_in    = NUM_WIDTH'(s_axis_tdata);

  assign rem_shift = {rem_q, quo_q[PW-1]};
  assign diff      = {1'b0, rem_shift} - {2'b00, dvs_q};
  assign fits      = !diff[SUM_W+1];
  assign rem_next  = fits ? diff[SUM_W-1:0] : rem_shift[SUM_W-1:0];
  assign quo_next  = {quo_q[PW-2:0], fits};

  // After a trial division quo_q holds n / d and rem_q holds n % d. The loop
  // ends once d exceeds n / d, that is once d passes the square root.
  assign d_ext     = PW'(d_q);
  assign loop_done = d_ext > quo_q;
  assign pair      = quo_q != d_ext;
  assign sum_inc   = SUM_W'(d_q) + (pair ? SUM_W'(quo_q) : '0);
  assign cnt_inc   = pair ? CNT_W'(2) : CNT_W'(1);

  assign harm_dividend = PW'(n_q) * PW'(cnt_q);
  assign two_n         = SUM_W'(n_q) << 1;

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    d_d         = d_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    dvs_d       = dvs_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    out_cnt_d   = out_cnt_q;
    out_sum_d   = out_sum_q;
    out_perf_d  = out_perf_q;
    out_harm_d  = out_harm_q;

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    s_axis_tready = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          n_d    = n_in;
          rem_d  = '0;
          step_d = STEP_W'(PW - 1);
          if (n_in == '0) begin
            // Zero counts only the divisor one; go straight to the harmonic test,
            // whose dividend n times the count is zero.
            cnt_d   = CNT_W'(1);
            sum_d   = SUM_W'(1);
            quo_d   = '0;
            dvs_d   = SUM_W'(1);
            state_d = S_HARM;
          end else begin
            cnt_d   = '0;
            sum_d   = '0;
            d_d     = NUM_WIDTH'(1);
            quo_d   = PW'(n_in);
            dvs_d   = SUM_W'(1);
            state_d = S_TRIAL;
          end
        end
      end
      S_TRIAL, S_HARM: begin
        rem_d  = rem_next;
        quo_d  = quo_next;
        step_d = step_q - STEP_W'(1);
        if (step_q == '0) begin
          state_d = (state_q == S_TRIAL) ? S_CHECK : S_FINISH;
        end
      end
      S_CHECK: begin
        rem_d  = '0;
        step_d = STEP_W'(PW - 1);
        if (loop_done) begin
          quo_d   = harm_dividend;
          dvs_d   = sum_q;
          state_d = S_HARM;
        end else begin
          if (rem_q == '0) begin
            cnt_d = cnt_q + cnt_inc;
            sum_d = sum_q + sum_inc;
          end
          d_d     = d_q + NUM_WIDTH'(1);
          quo_d   = PW'(n_q);
          dvs_d   = SUM_W'(d_q) + SUM_W'(1);
          state_d = S_TRIAL;
        end
      end
      S_FINISH: begin
        // Wait for the result register to be free, then load it.
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_cnt_d   = (cnt_q > CNT_W'(CNT_MAX)) ? CNT_OUT_W'(CNT_MAX)
                                                   : cnt_q[CNT_OUT_W-1:0];
          out_sum_d   = (sum_q > SUM_W'(SUM_MAX)) ? SUM_OUT_W'(SUM_MAX)
                                                   : sum_q[SUM_OUT_W-1:0];
          out_perf_d  = (sum_q == two_n);
          out_harm_d  = (rem_q == '0);
          d_d         = '0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      d_q         <= '0;
      cnt_q       <= '0;
      sum_q       <= '0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      d_q         <= d_d;
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      step_q      <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q      <= rem_d;
    quo_q      <= quo_d;
    dvs_q      <= dvs_d;
    out_cnt_q  <= out_cnt_d;
    out_sum_q  <= out_sum_d;
    out_perf_q <= out_perf_d;
    out_harm_q <= out_harm_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, out_harm_q, out_perf_q, out_sum_q, out_cnt_q};

  // The divisor of a running division is never zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TRIAL || state_q == S_HARM) |-> (dvs_q != '0))
    else $error("divider runs with a zero divisor");

  // A finished trial division leaves a remainder below its divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK) |-> (rem_q < dvs_q))
    else $error("trial remainder not below the divisor");

  // An accepted item always starts a division in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == S_TRIAL || state_q == S_HARM))
    else $error("accepted item did not start the divider");

  // A freshly loaded result always reports at least one divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH && state_d == S_IDLE) |=> (out_cnt_q != '0 && out_sum_q != '0))
    else $error("result reports no divisors");

endmodule

`default_nettype wire
